### rtl/xrg_pkg.sv
package xrg_pkg;

    localparam int unsigned WordW = 64;

    localparam logic [WordW-1:0] GoldenStep = 64'h9e3779b97f4a7c15;
    localparam logic [WordW-1:0] MixMulA    = 64'hbf58476d1ce4e5b9;
    localparam logic [WordW-1:0] MixMulB    = 64'h94d049bb133111eb;

    typedef enum logic [1:0] {
        CMD_RAW    = 2'd0,
        CMD_BOUND  = 2'd1,
        CMD_RESEED = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_DRAW,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_MUL_CUT,
        OP_MOD_START,
        OP_SEED_INIT,
        OP_MIX_ADD,
        OP_MIX_A,
        OP_MIX_B,
        OP_MIX_STORE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] slot;
    } t_ctrl;

    typedef struct packed {
        logic div_done;
        logic small_n;
        logic below_cut;
        logic mul_done;
    } t_stat;

    localparam logic [WordW-1:0] AllOnes = '1;

endpackage

### rtl/xoshiro256ss_random_generator_top.sv
// xoshiro256** generator. Input word: command 0 raw draw, 1 draw below range_limit,
// 2 reseed from the seed register (no result), 3 ignored. One word is worked at a time.
// The 64-bit seed register sits at APB addresses 0 to 7 (paddr[3] low). A raw draw's word
// passes the draw state and the controller's result flag into the output register before
// it is offered. A bounded draw runs the cutoff division, the cutoff product, draws until
// one lies below the cutoff (rejected ones are drawn again) and the modulo, all on one
// shared bit-serial divider and one 32x32 multiplier; a limit of 0 or 1 answers 0.
// Reseed and the reset expansion fill the four state words from the seed. The output
// register lets the next input word be accepted while a result waits; a second finished
// result holds off input until that register frees.
module xoshiro256ss_random_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [1:0] command, [65:2] range_limit, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] random_value
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [63:0] r_seed, r_out;
    logic        r_out_valid;
    xrg_pkg::t_ctrl ctrl;
    xrg_pkg::t_stat stat;
    logic [63:0] draw_w, rem_w, result_w;
    logic sel_rem, out_valid, in_ready, slot_free;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (psel && penable && pwrite && !paddr[3]) begin
            r_seed <= pwdata;
        end
    end
    assign prdata = paddr[3] ? 64'd0 : r_seed;

    assign slot_free = !r_out_valid || m_axis_tready;

    xrg_control u_ctl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_axis_tvalid),
        .i_cmd      (s_axis_tdata[1:0]),
        .o_in_ready (in_ready),
        .o_out_valid(out_valid),
        .i_out_ready(slot_free),
        .o_sel_rem  (sel_rem),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    xrg_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_ctrl (ctrl),
        .i_limit(s_axis_tdata[65:2]),
        .i_seed (r_seed),
        .o_stat (stat),
        .o_draw (draw_w),
        .o_rem  (rem_w)
    );

    // small limit answers zero whatever the remainder register holds
    assign result_w = sel_rem ? (stat.small_n ? 64'd0 : rem_w) : draw_w;

    // move the finished word out so the datapath can take the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_valid && slot_free) begin
            r_out       <= result_w;
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
endmodule

### rtl/xrg_datapath.sv
module xrg_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  xrg_pkg::t_ctrl             i_ctrl,
    input  logic [xrg_pkg::WordW-1:0]  i_limit,
    input  logic [xrg_pkg::WordW-1:0]  i_seed,
    output xrg_pkg::t_stat             o_stat,
    output logic [xrg_pkg::WordW-1:0]  o_draw,
    output logic [xrg_pkg::WordW-1:0]  o_rem
);
    localparam int W = xrg_pkg::WordW;

    logic [W-1:0] r_s0, r_s1, r_s2, r_s3;
    logic [W-1:0] r_n;
    logic [W-1:0] r_v;
    // shared restoring divider: quotient/dividend in r_q, remainder in r_r
    logic [W-1:0] r_q, r_r;
    logic [6:0]   r_cnt;
    logic [W-1:0] r_cut;
    logic [W-1:0] r_ctr, r_z;
    // 64x64 low product built from three 32x32 partial products, one per phase
    logic [1:0]   r_mph;
    logic [W-1:0] r_acc;
    logic         r_div_busy;

    logic [W-1:0] s1x5, rot, res9, t17;
    logic [W:0]   trial;
    logic [W-1:0] mul_a, mul_b, pp;
    logic [31:0]  pa, pb;

    assign s1x5 = (r_s1 << 2) + r_s1;
    assign rot  = {s1x5[W-8:0], s1x5[W-1:W-7]};
    assign res9 = (rot << 3) + rot;
    assign t17  = r_s1 << 17;
    assign trial = {r_r, r_q[W-1]} - {1'b0, r_n};

    always_comb begin
        mul_a = r_z;
        mul_b = xrg_pkg::MixMulA;
        if (i_ctrl.op == xrg_pkg::OP_MUL_CUT) begin
            mul_a = r_q;
            mul_b = r_n;
        end else if (i_ctrl.op == xrg_pkg::OP_MIX_B) begin
            mul_b = xrg_pkg::MixMulB;
        end
        unique case (r_mph)
            2'd0:    begin pa = mul_a[31:0];  pb = mul_b[31:0];  end
            2'd1:    begin pa = mul_a[63:32]; pb = mul_b[31:0];  end
            default: begin pa = mul_a[31:0];  pb = mul_b[63:32]; end
        endcase
        pp = W'(pa) * W'(pb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_mph <= '0;
            r_div_busy <= 1'b0;
        end else begin
            unique case (i_ctrl.op)
                xrg_pkg::OP_LOAD: begin
                    r_n <= i_limit;
                    r_mph <= '0;
                end
                xrg_pkg::OP_DRAW: begin
                    r_v  <= res9;
                    r_s2 <= r_s2 ^ r_s0 ^ t17;
                    r_s3 <= {(r_s3 ^ r_s1) << 45} | ((r_s3 ^ r_s1) >> 19);
                    r_s1 <= r_s1 ^ r_s2 ^ r_s0;
                    r_s0 <= r_s0 ^ r_s3 ^ r_s1;
                    r_mph <= '0;
                end
                xrg_pkg::OP_DIV_START: begin
                    r_q <= xrg_pkg::AllOnes;
                    r_r <= '0;
                    r_cnt <= 7'd64;
                end
                xrg_pkg::OP_MOD_START: begin
                    r_q <= r_v;
                    r_r <= '0;
                    r_cnt <= 7'd64;
                end
                xrg_pkg::OP_DIV_STEP: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 7'd1;
                        if (!trial[W]) begin
                            r_r <= trial[W-1:0];
                            r_q <= {r_q[W-2:0], 1'b1};
                        end else begin
                            r_r <= {r_r[W-2:0], r_q[W-1]};
                            r_q <= {r_q[W-2:0], 1'b0};
                        end
                    end
                end
                xrg_pkg::OP_MUL_CUT, xrg_pkg::OP_MIX_A, xrg_pkg::OP_MIX_B: begin
                    if (r_mph == 2'd0) begin
                        r_acc <= pp;
                        r_mph <= 2'd1;
                    end else if (r_mph == 2'd1) begin
                        r_acc <= r_acc + {pp[31:0], 32'd0};
                        r_mph <= 2'd2;
                    end else if (r_mph == 2'd2) begin
                        r_mph <= 2'd3;
                        if (i_ctrl.op == xrg_pkg::OP_MUL_CUT)
                            r_cut <= r_acc + {pp[31:0], 32'd0};
                        else if (i_ctrl.op == xrg_pkg::OP_MIX_A)
                            r_z <= (r_acc + {pp[31:0], 32'd0})
                                 ^ ((r_acc + {pp[31:0], 32'd0}) >> 27);
                        else
                            r_z <= (r_acc + {pp[31:0], 32'd0})
                                 ^ ((r_acc + {pp[31:0], 32'd0}) >> 31);
                    end else begin
                        r_mph <= 2'd0;
                    end
                end
                xrg_pkg::OP_SEED_INIT: r_ctr <= i_seed;
                xrg_pkg::OP_MIX_ADD: begin
                    r_ctr <= r_ctr + xrg_pkg::GoldenStep;
                    r_z <= (r_ctr + xrg_pkg::GoldenStep)
                         ^ ((r_ctr + xrg_pkg::GoldenStep) >> 30);
                    r_mph <= '0;
                end
                xrg_pkg::OP_MIX_STORE: begin
                    r_mph <= '0;
                    unique case (i_ctrl.slot)
                        2'd0: r_s0 <= r_z;
                        2'd1: r_s1 <= r_z;
                        2'd2: r_s2 <= r_z;
                        default: r_s3 <= r_z;
                    endcase
                end
                default: ;
            endcase
            r_div_busy <= (r_cnt != '0);
        end
    end

    assign o_stat.div_done  = (r_cnt == '0);
    assign o_stat.small_n   = (r_n < W'(2));
    assign o_stat.below_cut = (r_v < r_cut);
    assign o_stat.mul_done  = (r_mph == 2'd3);
    assign o_draw = r_v;
    assign o_rem  = r_r;

    a_rem_lt_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_busy && r_cnt == '0) |-> (r_r < r_n))
        else $error("remainder not below limit");
    a_cnt_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && i_ctrl.op == xrg_pkg::OP_DIV_STEP) |=> (r_cnt == $past(r_cnt) - 7'd1))
        else $error("divider count skipped");
    a_mph_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mph == 2'd3) |=> (r_mph == 2'd0 || i_ctrl.op == xrg_pkg::OP_IDLE
                             || $past(i_ctrl.op) == xrg_pkg::OP_IDLE))
        else $error("multiplier phase stuck");
endmodule

### rtl/xrg_control.sv
module xrg_control (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [1:0]                i_cmd,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_sel_rem,
    input  xrg_pkg::t_stat            i_stat,
    output xrg_pkg::t_ctrl            o_ctrl
);
    typedef enum logic [3:0] {
        S_RESET, S_IDLE, S_RAW, S_BLOAD, S_DIV, S_MULCUT, S_BDRAW, S_BCHK,
        S_MOD, S_MODRUN, S_MADD, S_MA, S_MB, S_MST
    } t_state;

    t_state     r_state;
    logic [1:0] r_slot;
    logic       r_out_valid, r_sel_rem, r_first;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_sel_rem   = r_sel_rem;

    always_comb begin
        o_ctrl.slot = r_slot;
        o_ctrl.op = xrg_pkg::OP_IDLE;
        unique case (r_state)
            S_RESET:  o_ctrl.op = xrg_pkg::OP_SEED_INIT;
            S_IDLE:   if (i_in_valid && o_in_ready) o_ctrl.op =
                          (xrg_pkg::t_cmd'(i_cmd) == xrg_pkg::CMD_RESEED)
                          ? xrg_pkg::OP_SEED_INIT : xrg_pkg::OP_LOAD;
            S_RAW:    o_ctrl.op = xrg_pkg::OP_DRAW;
            S_BLOAD:  o_ctrl.op = xrg_pkg::OP_DIV_START;
            S_DIV:    o_ctrl.op = xrg_pkg::OP_DIV_STEP;
            S_MULCUT: o_ctrl.op = xrg_pkg::OP_MUL_CUT;
            S_BDRAW:  o_ctrl.op = xrg_pkg::OP_DRAW;
            S_BCHK:   o_ctrl.op = xrg_pkg::OP_IDLE;
            S_MOD:    o_ctrl.op = xrg_pkg::OP_MOD_START;
            S_MODRUN: o_ctrl.op = xrg_pkg::OP_DIV_STEP;
            S_MADD:   o_ctrl.op = xrg_pkg::OP_MIX_ADD;
            S_MA:     o_ctrl.op = xrg_pkg::OP_MIX_A;
            S_MB:     o_ctrl.op = xrg_pkg::OP_MIX_B;
            S_MST:    o_ctrl.op = xrg_pkg::OP_MIX_STORE;
            default:  o_ctrl.op = xrg_pkg::OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RESET;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            r_sel_rem   <= 1'b0;
            r_first     <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_RESET: begin
                    r_slot <= '0;
                    r_state <= S_MADD;
                end
                S_IDLE: if (i_in_valid && o_in_ready) begin
                    unique case (xrg_pkg::t_cmd'(i_cmd))
                        xrg_pkg::CMD_RAW:    r_state <= S_RAW;
                        xrg_pkg::CMD_BOUND:  r_state <= S_BLOAD;
                        xrg_pkg::CMD_RESEED: begin
                            r_slot <= '0;
                            r_state <= S_MADD;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_RAW: begin
                    r_sel_rem <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_BLOAD: begin
                    if (i_stat.small_n) begin
                        // zero limit or one: answer zero, leave state
                        r_sel_rem <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_first <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: if (i_stat.div_done && !r_first) r_state <= S_MULCUT;
                       else r_first <= 1'b0;
                S_MULCUT: if (i_stat.mul_done) r_state <= S_BDRAW;
                S_BDRAW:  r_state <= S_BCHK;
                S_BCHK:   r_state <= i_stat.below_cut ? S_MOD : S_BDRAW;
                S_MOD: begin
                    r_first <= 1'b1;
                    r_state <= S_MODRUN;
                end
                S_MODRUN: if (i_stat.div_done && !r_first) begin
                    r_sel_rem <= 1'b1;
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end else r_first <= 1'b0;
                S_MADD: r_state <= S_MA;
                S_MA:   if (i_stat.mul_done) r_state <= S_MB;
                S_MB:   if (i_stat.mul_done) r_state <= S_MST;
                S_MST: begin
                    r_slot <= r_slot + 2'd1;
                    r_state <= (r_slot == 2'd3) ? S_IDLE : S_MADD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE && !r_out_valid))
        else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result dropped");
    a_reject_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BCHK && !i_stat.below_cut) |=> (r_state == S_BDRAW))
        else $error("rejected draw not retried");
endmodule

### test/xoshiro256ss_random_generator_top_tb.sv
`timescale 1ns / 1ps

module xoshiro256ss_random_generator_top_tb;

    localparam int unsigned CycleLimit = 3000000;
    localparam int unsigned SettleCycles = 120;

    typedef struct {
        xrg_pkg::t_cmd cmd;
        logic [63:0]   limit;
    } t_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // [1:0] command, [65:2] range_limit, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [63:0] random_value
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    xoshiro256ss_random_generator_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [63:0] gen_state[4];
    logic [63:0] seed_reg;
    logic [63:0] expected_values[$];
    t_req        pending_reqs[$];
    t_req        driven_req;
    int unsigned gap_left;
    bit          no_idle;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned raw_count, bound_count, reseed_count, reject_count, result_count;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [63:0] rotl(input logic [63:0] x, input int k);
        return (x << k) | (x >> (64 - k));
    endfunction

    function automatic logic [63:0] splitmix_next(ref logic [63:0] ctr);
        logic [63:0] z;
        ctr = ctr + xrg_pkg::GoldenStep;
        z = ctr;
        z = (z ^ (z >> 30)) * xrg_pkg::MixMulA;
        z = (z ^ (z >> 27)) * xrg_pkg::MixMulB;
        return z ^ (z >> 31);
    endfunction

    task automatic expand_seed(input logic [63:0] value);
        logic [63:0] ctr;
        ctr = value;
        for (int i = 0; i < 4; i++) gen_state[i] = splitmix_next(ctr);
    endtask

    function automatic logic [63:0] next_output();
        logic [63:0] res;
        logic [63:0] t;
        res = rotl(gen_state[1] * 64'd5, 7) * 64'd9;
        t = gen_state[1] << 17;
        gen_state[2] ^= gen_state[0];
        gen_state[3] ^= gen_state[1];
        gen_state[1] ^= gen_state[2];
        gen_state[0] ^= gen_state[3];
        gen_state[2] ^= t;
        gen_state[3] = rotl(gen_state[3], 45);
        return res;
    endfunction

    task automatic predict_word(input t_req r);
        logic [63:0] cutoff;
        logic [63:0] v;
        case (r.cmd)
            xrg_pkg::CMD_RAW: begin
                expected_values.push_back(next_output());
                raw_count++;
            end
            xrg_pkg::CMD_BOUND: begin
                bound_count++;
                if (r.limit < 64'd2) begin
                    expected_values.push_back(64'd0);
                end else begin
                    cutoff = (xrg_pkg::AllOnes / r.limit) * r.limit;
                    v = next_output();
                    while (v >= cutoff) begin
                        reject_count++;
                        v = next_output();
                    end
                    expected_values.push_back(v % r.limit);
                end
            end
            xrg_pkg::CMD_RESEED: begin
                expand_seed(seed_reg);
                reseed_count++;
            end
            default: ;
        endcase
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sender: predict the accepted word, then load the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_word(driven_req);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    driven_req = pending_reqs.pop_front();
                    s_axis_tdata <= {6'd0, driven_req.limit, driven_req.cmd};
                    s_axis_tvalid <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each word, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                result_count++;
                if (expected_values.size() == 0) begin
                    $display("%0t: unexpected word, actual %h", $time, m_axis_tdata);
                    error_count++;
                end else begin
                    if (m_axis_tdata !== expected_values[0]) begin
                        $display("%0t: random_value mismatch, expected %h actual %h",
                                 $time, expected_values[0], m_axis_tdata);
                        error_count++;
                    end
                    void'(expected_values.pop_front());
                end
            end
            if (no_idle) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                                  ($urandom_range(0, 99) < 10 && !m_axis_tready);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("%0t: timeout, %0d words still expected", $time, expected_values.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_seed(input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'd0;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        seed_reg = value;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_values.size() > 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_limit();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return 64'($urandom_range(0, 1));
        if (roll < 45) return 64'($urandom_range(2, 1000));
        if (roll < 60) return 64'd1 << $urandom_range(1, 63);
        if (roll < 75) return {1'b1, 31'd0, 32'($urandom_range(0, 255))};
        if (roll < 85) return xrg_pkg::AllOnes - 64'($urandom_range(0, 3));
        return {$urandom, $urandom};
    endfunction

    task automatic queue_random(input int unsigned n);
        t_req r;
        int unsigned roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) r.cmd = xrg_pkg::CMD_RAW;
            else if (roll < 88) r.cmd = xrg_pkg::CMD_BOUND;
            else if (roll < 95) r.cmd = xrg_pkg::CMD_RESEED;
            else r.cmd = xrg_pkg::CMD_NONE;
            r.limit = (r.cmd == xrg_pkg::CMD_BOUND) ? pick_limit() : {$urandom, $urandom};
            pending_reqs.push_back(r);
        end
    endtask

    task automatic queue_req(input xrg_pkg::t_cmd c, input logic [63:0] lim);
        t_req r;
        r.cmd = c;
        r.limit = lim;
        pending_reqs.push_back(r);
    endtask

    initial begin
        logic [63:0] seeds[6];
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 4'd0;
        pwdata = 64'd0;
        error_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        seed_reg = 64'd0;
        expand_seed(64'd0);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset state, limit extremes, reseed, unused code
        queue_req(xrg_pkg::CMD_RAW, xrg_pkg::AllOnes);
        queue_req(xrg_pkg::CMD_BOUND, 64'd0);
        queue_req(xrg_pkg::CMD_BOUND, 64'd1);
        queue_req(xrg_pkg::CMD_BOUND, 64'd2);
        queue_req(xrg_pkg::CMD_BOUND, 64'd3);
        queue_req(xrg_pkg::CMD_BOUND, xrg_pkg::AllOnes);
        queue_req(xrg_pkg::CMD_BOUND, 64'h8000_0000_0000_0000);
        queue_req(xrg_pkg::CMD_BOUND, 64'h8000_0000_0000_0001);
        queue_req(xrg_pkg::CMD_BOUND, 64'h8000_0000_0000_0001);
        queue_req(xrg_pkg::CMD_BOUND, 64'hAAAA_AAAA_AAAA_AAAB);
        queue_req(xrg_pkg::CMD_NONE, xrg_pkg::AllOnes);
        queue_req(xrg_pkg::CMD_RAW, 64'd0);
        queue_req(xrg_pkg::CMD_RESEED, 64'd0);
        queue_req(xrg_pkg::CMD_RAW, 64'd0);
        queue_req(xrg_pkg::CMD_BOUND, 64'd10);
        queue_req(xrg_pkg::CMD_NONE, 64'd0);
        queue_req(xrg_pkg::CMD_RAW, 64'd0);
        drain();

        seeds = '{xrg_pkg::AllOnes, 64'd1, 64'd0, {$urandom, $urandom},
                  64'h8000_0000_0000_0000, {$urandom, $urandom}};
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            no_idle = (i == 2);
            queue_req(xrg_pkg::CMD_RESEED, 64'd0);
            queue_req(xrg_pkg::CMD_RAW, 64'd0);
            queue_random(235);
            drain();
        end
        no_idle = 1'b0;

        $display("Covered %0d raw and %0d bounded draws (%0d rejected), %0d reseeds,",
                 raw_count, bound_count, reject_count, reseed_count);
        $display("%0d words checked across %0d seed settings.", result_count, 7);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
